### sv/kphs_pkg.sv
`timescale 1ns / 1ps

package kphs_pkg;

    // Field and register widths
    localparam int TIME_W    = 16;
    localparam int CNT_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int LANES     = 2;

    // Register reset values
    localparam logic [TIME_W-1:0] DOWN_RESET = 16'd10;
    localparam logic [TIME_W-1:0] HOLD_RESET = 16'd100;

    // Item kind on the input channel
    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOWN_TIME = 1'b0,
        CFG_HOLD_TIME = 1'b1
    } cfg_idx_t;

    // Message kind
    typedef enum logic {
        KIND_PRESS = 1'b0,
        KIND_HOLD  = 1'b1
    } kind_t;

    // One queued message: bit 0 key, bit 1 kind
    typedef struct packed {
        logic kind;
        logic key;
    } msg_t;

    // One FIFO row: the messages queued by one tick, in key order
    typedef struct packed {
        logic two;
        msg_t slot1;
        msg_t slot0;
    } row_t;

    // Event raised by one key lane on a tick
    typedef struct packed {
        logic valid;
        logic kind;
    } key_event_t;

    // Item control from the top level to the FIFO
    typedef struct packed {
        logic advance;
        logic tick;
        logic read;
    } fifo_ctrl_t;

    // Registered result fields from the FIFO
    typedef struct packed {
        logic       msg_valid;
        logic       key;
        logic       kind;
        logic [1:0] drops;
    } fifo_msg_t;

endpackage

### sv/key_press_hold_scanner_fifo.sv
`timescale 1ns / 1ps

// Key press and hold scanner with a message FIFO.
// Input channel (s_valid/s_ready): each transfer is a scan tick (s_func = tick)
// carrying the raw active-low key levels, or a read (s_func = read) that pops
// the oldest message. Every item yields exactly one result on the m_ channel:
// the popped message (m_msg_valid/key/kind), the messages dropped on a full
// FIFO during this tick, and the FIFO fill level after the item.
// The result is in the output register the cycle after the input transfer.
// Throughput is one item per cycle while m_ready takes each result; the key
// counters update on each tick and the message RAM takes one row per cycle, each
// row holding all messages a tick produced, so its single write port is enough.
// While a result waits, a new item is taken in the same cycle that m_ready
// takes the old one; with m_ready low, s_ready stays low and the result holds.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes down_time or hold_time and
// is meant for an idle block.
// Reset (aresetn, synchronous, active low) clears the key counts and empties
// the FIFO at once and loads down_time 10 and hold_time 100; no clearing pass.

module key_press_hold_scanner_fifo #(
    parameter int NUM_KEYS   = 2,
    parameter int FIFO_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [kphs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kphs_pkg::TIME_W-1:0]         cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [1:0]                          s_key_levels,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_msg_valid,
    output logic                                m_msg_key,
    output logic                                m_msg_kind,
    output logic [1:0]                          m_drop_count,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     m_fill_level
);

    logic [kphs_pkg::TIME_W-1:0] down_time_reg, hold_time_reg;
    logic                        m_valid_reg;
    logic                        advance;

    kphs_pkg::fifo_ctrl_t                        ctrl;
    kphs_pkg::key_event_t [kphs_pkg::LANES-1:0]  ev;
    kphs_pkg::fifo_msg_t                         res;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_time_reg <= kphs_pkg::DOWN_RESET;
            hold_time_reg <= kphs_pkg::HOLD_RESET;
        end else if (cfg_we) begin
            case (kphs_pkg::cfg_idx_t'(cfg_index))
                kphs_pkg::CFG_DOWN_TIME: begin
                    down_time_reg <= cfg_wdata;
                end
                kphs_pkg::CFG_HOLD_TIME: begin
                    hold_time_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: output register decouples the two sides
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign advance = s_valid && s_ready;

    always_comb begin
        ctrl.advance = advance;
        ctrl.tick    = advance && (s_func == kphs_pkg::FUNC_TICK);
        ctrl.read    = advance && (s_func == kphs_pkg::FUNC_READ);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // One counter lane per key; unused lanes raise nothing
    for (genvar i = 0; i < kphs_pkg::LANES; i++) begin : g_lane
        if (i < NUM_KEYS) begin : g_key
            kphs_key_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .tick      (ctrl.tick),
                .pressed   (!s_key_levels[i]),
                .down_time (down_time_reg),
                .hold_time (hold_time_reg),
                .ev        (ev[i])
            );
        end else begin : g_none
            assign ev[i] = '0;
        end
    end

    kphs_msg_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .ev         (ev),
        .res        (res),
        .fill_level (m_fill_level)
    );

    assign m_valid      = m_valid_reg;
    assign m_msg_valid  = res.msg_valid;
    assign m_msg_key    = res.key;
    assign m_msg_kind   = res.kind;
    assign m_drop_count = res.drops;

    // A pop never comes with drops
    a_pop_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_valid |-> m_drop_count == 2'd0)
        else $error("pop result reports dropped messages");

    // A tick never pops a message
    a_tick_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == kphs_pkg::FUNC_TICK |=> m_valid && !m_msg_valid)
        else $error("tick produced a popped message");

    // After a pop the FIFO cannot be full
    a_pop_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_msg_valid |-> m_fill_level < FIFO_DEPTH)
        else $error("FIFO still full after a pop");

endmodule

### sv/kphs_ram.sv
`timescale 1ns / 1ps

module kphs_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/kphs_key_lane.sv
`timescale 1ns / 1ps

module kphs_key_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           tick,
    input  logic                           pressed,
    input  logic [kphs_pkg::TIME_W-1:0]    down_time,
    input  logic [kphs_pkg::TIME_W-1:0]    hold_time,
    output kphs_pkg::key_event_t           ev
);

    logic [kphs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [kphs_pkg::CNT_W-1:0] inc, down_ext, hold_ext, down_one, hold_one;

    // Debounce and hold thresholds on the incremented count
    always_comb begin
        inc      = cnt_reg + 1'b1;
        down_ext = {1'b0, down_time};
        hold_ext = {1'b0, hold_time};
        down_one = down_ext + 1'b1;
        hold_one = hold_ext + 1'b1;
        cnt_next = cnt_reg;
        ev       = '0;
        if (tick) begin
            if (!pressed) begin
                cnt_next = '0;
            end else if (inc <= down_ext) begin
                cnt_next = inc;
            end else if (inc == down_one) begin
                cnt_next = inc;
                ev.valid = 1'b1;
                ev.kind  = kphs_pkg::KIND_PRESS;
            end else if (inc <= hold_ext) begin
                cnt_next = inc;
            end else if (inc == hold_one) begin
                cnt_next = inc;
                ev.valid = 1'b1;
                ev.kind  = kphs_pkg::KIND_HOLD;
            end else begin
                // past both thresholds: fall back so hold repeats
                cnt_next = down_one;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/kphs_msg_fifo.sv
`timescale 1ns / 1ps

module kphs_msg_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  kphs_pkg::fifo_ctrl_t                     ctrl,
    input  kphs_pkg::key_event_t [kphs_pkg::LANES-1:0] ev,
    output kphs_pkg::fifo_msg_t                      res,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]          fill_level
);

    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH+1);
    localparam int ROW_W = $bits(kphs_pkg::row_t);

    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] LAST_CNT = CW'(FIFO_DEPTH - 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(FIFO_DEPTH - 1);

    function automatic logic [AW-1:0] next_row(input logic [AW-1:0] p);
        return (p == LAST_ROW) ? '0 : p + 1'b1;
    endfunction

    // Control state
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] wr_row_reg, wr_row_next;
    logic [AW-1:0] rd_row_reg, rd_row_next;
    logic          pend_reg, pend_next;

    // Result stage
    logic          msg_valid_reg;
    logic          sel_reg, sel_next;
    logic [1:0]    drop_reg;
    logic [CW-1:0] fill_reg;

    logic [1:0]           n_ev, acc, drops;
    logic                 wr_en, re, pop;
    logic [AW-1:0]        raddr;
    kphs_pkg::row_t       wr_row_data;
    kphs_pkg::row_t       q;
    logic [ROW_W-1:0]     q_raw;

    // Pack the tick's events into one row, dropping what does not fit
    always_comb begin
        n_ev = {1'b0, ev[0].valid} + {1'b0, ev[1].valid};
        if (n_ev == 2'd0 || count_reg == FULL_CNT) begin
            acc = 2'd0;
        end else if (n_ev == 2'd2 && count_reg == LAST_CNT) begin
            acc = 2'd1;
        end else begin
            acc = n_ev;
        end
        drops = n_ev - acc;

        wr_row_data.slot0.key  = !ev[0].valid;
        wr_row_data.slot0.kind = ev[0].valid ? ev[0].kind : ev[1].kind;
        wr_row_data.slot1.key  = 1'b1;
        wr_row_data.slot1.kind = ev[1].kind;
        wr_row_data.two        = (acc == 2'd2);

        wr_en       = ctrl.tick && (acc != 2'd0);
        wr_row_next = wr_en ? next_row(wr_row_reg) : wr_row_reg;
    end

    // Pop side: the RAM output keeps the row of the last pop
    always_comb begin
        pop         = ctrl.read && (count_reg != '0);
        re          = 1'b0;
        raddr       = rd_row_reg;
        rd_row_next = rd_row_reg;
        pend_next   = pend_reg;
        sel_next    = sel_reg;
        if (pop) begin
            if (pend_reg && q.two) begin
                // second message of the row already on hand
                sel_next    = 1'b1;
                rd_row_next = next_row(rd_row_reg);
                pend_next   = 1'b0;
            end else if (pend_reg) begin
                re          = 1'b1;
                raddr       = next_row(rd_row_reg);
                rd_row_next = next_row(rd_row_reg);
                sel_next    = 1'b0;
                pend_next   = 1'b1;
            end else begin
                re          = 1'b1;
                sel_next    = 1'b0;
                pend_next   = 1'b1;
            end
        end
    end

    // Message count
    always_comb begin
        if (ctrl.tick) begin
            count_next = count_reg + CW'(acc);
        end else if (pop) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_row_reg <= '0;
            rd_row_reg <= '0;
            pend_reg   <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_row_reg <= wr_row_next;
            rd_row_reg <= rd_row_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
        if (ctrl.advance) begin
            msg_valid_reg <= pop;
            drop_reg      <= ctrl.tick ? drops : 2'd0;
            fill_reg      <= count_next;
        end
    end

    kphs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_row_reg),
        .wdata (wr_row_data),
        .re    (re),
        .raddr (raddr),
        .rdata (q_raw)
    );

    assign q = kphs_pkg::row_t'(q_raw);

    // Result fields; message fields read as zero without a pop
    always_comb begin
        res.msg_valid = msg_valid_reg;
        res.key       = msg_valid_reg && (sel_reg ? q.slot1.key  : q.slot0.key);
        res.kind      = msg_valid_reg && (sel_reg ? q.slot1.kind : q.slot0.kind);
        res.drops     = drop_reg;
    end

    assign fill_level = fill_reg;

endmodule

### dv/key_event_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result and
// compares it field by field against what the block returns.
module key_event_checker #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [kphs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kphs_pkg::TIME_W-1:0]         cfg_wdata,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_func,
    input  logic [1:0]                          s_key_levels,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_msg_valid,
    input  logic                                m_msg_key,
    input  logic                                m_msg_kind,
    input  logic [1:0]                          m_drop_count,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]     m_fill_level,

    output int                                  pending,
    output int                                  fail_count
);

    import kphs_pkg::*;

    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct {
        logic              msg_valid;
        logic              key;
        logic              kind;
        logic [1:0]        drops;
        logic [FILL_W-1:0] fill;
    } key_result_t;

    // Predictor state
    int unsigned  down_ticks;
    int unsigned  hold_ticks;
    int unsigned  held_ticks [LANES];
    msg_t         msg_queue [$];

    // Results still owed by the block, oldest first
    key_result_t  owed_results [$];
    key_result_t  oldest;
    int           mismatches;

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    // Next result for one item; updates the key counts and the message queue
    function automatic key_result_t scan_or_pop(func_t func, logic [1:0] levels);
        key_result_t r;
        msg_t        m;
        logic        queue_it;
        kind_t       kd;
        r = '{default: '0};
        if (func == FUNC_TICK) begin
            for (int k = 0; k < LANES; k++) begin
                if (levels[k]) begin
                    held_ticks[k] = 0;
                    continue;
                end
                held_ticks[k]++;
                queue_it = 1'b0;
                kd       = KIND_PRESS;
                if (held_ticks[k] <= down_ticks) begin
                    // still debouncing
                end else if (held_ticks[k] == down_ticks + 1) begin
                    queue_it = 1'b1;
                end else if (held_ticks[k] <= hold_ticks) begin
                    // waiting for the hold threshold
                end else if (held_ticks[k] == hold_ticks + 1) begin
                    queue_it = 1'b1;
                    kd       = KIND_HOLD;
                end else begin
                    // past both thresholds: back to just-pressed so holds repeat
                    held_ticks[k] = down_ticks + 1;
                end
                if (queue_it) begin
                    if (msg_queue.size() >= FIFO_DEPTH) begin
                        r.drops++;
                    end else begin
                        m.key  = k[0];
                        m.kind = kd;
                        msg_queue.push_back(m);
                    end
                end
            end
        end else if (msg_queue.size() != 0) begin
            m           = msg_queue.pop_front();
            r.msg_valid = 1'b1;
            r.key       = m.key;
            r.kind      = m.kind;
        end
        r.fill = FILL_W'(msg_queue.size());
        return r;
    endfunction

    function automatic int field_diff(string name, logic [FILL_W-1:0] want,
                                      logic [FILL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            down_ticks = DOWN_RESET;
            hold_ticks = HOLD_RESET;
            held_ticks = '{default: 0};
            msg_queue.delete();
            owed_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DOWN_TIME: down_ticks = cfg_wdata;
                    CFG_HOLD_TIME: hold_ticks = cfg_wdata;
                    default: ;
                endcase
            end

            // result transfer: check against the oldest owed result
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual valid %0b key %0b kind %0b drops %0d fill %0d"},
                             $time, m_msg_valid, m_msg_key, m_msg_kind, m_drop_count,
                             m_fill_level);
                    mismatches++;
                end else begin
                    oldest = owed_results.pop_front();
                    mismatches += field_diff("msg_valid", oldest.msg_valid, m_msg_valid);
                    mismatches += field_diff("msg_key", oldest.key, m_msg_key);
                    mismatches += field_diff("msg_kind", oldest.kind, m_msg_kind);
                    mismatches += field_diff("drop_count", oldest.drops, m_drop_count);
                    mismatches += field_diff("fill_level", oldest.fill, m_fill_level);
                end
            end

            // input transfer: predict its result
            if (s_valid && s_ready)
                owed_results.push_back(scan_or_pop(func_t'(s_func), s_key_levels));
        end
        pending    <= owed_results.size();
        fail_count <= mismatches;
    end

endmodule

### dv/key_press_hold_scanner_fifo_test.sv
`timescale 1ns / 1ps

module key_press_hold_scanner_fifo_test;

    import kphs_pkg::*;

    localparam int FIFO_DEPTH = 256;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF   = 400;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [TIME_W-1:0]      cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_func;
    logic [1:0]             s_key_levels;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_msg_valid;
    logic                   m_msg_key;
    logic                   m_msg_kind;
    logic [1:0]             m_drop_count;
    logic [FILL_W-1:0]      m_fill_level;

    int                     pending;
    int                     fail_count;
    int                     idle_cycles;
    bit                     tx_no_gap;
    bit                     rx_no_gap;
    int                     results_taken;

    key_press_hold_scanner_fifo #(
        .NUM_KEYS   (2),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_msg_valid  (m_msg_valid),
        .m_msg_key    (m_msg_key),
        .m_msg_kind   (m_msg_kind),
        .m_drop_count (m_drop_count),
        .m_fill_level (m_fill_level)
    );

    key_event_checker #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_msg_valid  (m_msg_valid),
        .m_msg_key    (m_msg_key),
        .m_msg_kind   (m_msg_kind),
        .m_drop_count (m_drop_count),
        .m_fill_level (m_fill_level),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("key_press_hold_scanner_fifo regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, no-stall stretches and two long hold-offs
    initial begin
        int n;
        m_ready       = 1'b0;
        rx_no_gap     = 1'b0;
        results_taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 64 == 0)
                rx_no_gap = ($urandom_range(0, 2) == 0);
            if (results_taken == 500 || results_taken == 1300)
                n = HOLD_OFF;
            else
                n = rx_no_gap ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    // One input transfer, after a random gap unless tx_no_gap is set
    task automatic send_item(func_t func, logic [1:0] levels);
        int n;
        n = tx_no_gap ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_key_levels <= levels;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every owed result has come back and the block is quiet
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_times(logic [TIME_W-1:0] down, logic [TIME_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DOWN_TIME;
        cfg_wdata <= down;
        @(posedge aclk);
        cfg_index <= CFG_HOLD_TIME;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Random keys that mostly stay put, mixed with reads and some noisy ticks
    task automatic run_phase(int down, int hold, int items, int toggle_div, int read_pct);
        logic [1:0] levels;
        settle();
        write_times(TIME_W'(down), TIME_W'(hold));
        tx_no_gap = ($urandom_range(0, 3) == 0);
        levels    = 2'($urandom_range(0, 3));
        repeat (items) begin
            if ($urandom_range(0, 99) < read_pct) begin
                send_item(FUNC_READ, 2'($urandom_range(0, 3)));
            end else begin
                for (int k = 0; k < LANES; k++)
                    if ($urandom_range(1, toggle_div) == 1)
                        levels[k] = ~levels[k];
                if ($urandom_range(0, 19) == 0)
                    send_item(FUNC_TICK, 2'($urandom_range(0, 3)));
                else
                    send_item(FUNC_TICK, levels);
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DOWN_TIME;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_func       = FUNC_TICK;
        s_key_levels = 2'b11;
        tx_no_gap    = 1'b0;
        idle_cycles  = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty read, press, hold, repeat hold, single keys, drain
        write_times(16'd1, 16'd3);
        send_item(FUNC_READ, 2'b11);
        send_item(FUNC_TICK, 2'b11);
        repeat (5) send_item(FUNC_TICK, 2'b00);
        send_item(FUNC_TICK, 2'b01);
        send_item(FUNC_TICK, 2'b01);
        send_item(FUNC_TICK, 2'b10);
        send_item(FUNC_TICK, 2'b10);
        repeat (8) send_item(FUNC_READ, 2'b00);

        // Reset values, then extremes and odd threshold orderings
        run_phase(10, 100, 150, 60, 30);
        run_phase(0, 0, 100, 6, 40);
        run_phase(3, 2, 120, 10, 35);
        run_phase(2, 2, 100, 10, 35);
        run_phase(2, 7, 150, 20, 35);
        run_phase(65535, 65535, 60, 4, 50);
        run_phase(0, 65535, 100, 8, 45);
        run_phase(65535, 0, 60, 6, 40);

        // Flood: both keys down with one tick of skew, ticks mixed with random reads, then a drain
        settle();
        write_times(16'd0, 16'd1);
        tx_no_gap = 1'b1;
        send_item(FUNC_TICK, 2'b10);
        repeat (280) begin
            if ($urandom_range(0, 15) == 0)
                send_item(FUNC_READ, 2'($urandom_range(0, 3)));
            else
                send_item(FUNC_TICK, 2'b00);
        end
        tx_no_gap = 1'b0;
        repeat (265) send_item(FUNC_READ, 2'($urandom_range(0, 3)));

        repeat (3) run_phase($urandom_range(0, 6), $urandom_range(0, 24), 120, 15, 35);
        run_phase(10, 100, 120, 80, 25);

        settle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("key_press_hold_scanner_fifo regression: pass");
        end else begin
            $display("key_press_hold_scanner_fifo regression: fail");
        end
        $finish;
    end

endmodule
